// ----- rtl/stwc_pkg.sv -----
package stwc_pkg;

   // Field widths fixed by the pixel stream format.
   localparam int PIX_W   = 8;
   localparam int ROW_W   = 11;
   localparam int OCOL_W  = 10;
   localparam int SIZE_W  = 11;
   localparam int SIM_W   = 5;
   localparam int BRI_W   = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;

   // Four stored lines travel together as one memory word.
   localparam int LINES  = 4;
   localparam int WORD_W = LINES * PIX_W;

   // Window geometry.
   localparam int WIN    = 5;
   localparam int CENTRE = 2;

   // Register defaults after reset.
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;
   localparam logic [PIX_W-1:0]  MIN_LEVEL_RST    = 8'd72;
   localparam logic [PIX_W-1:0]  NEAR_BAND_RST    = 8'd18;
   localparam logic [PIX_W-1:0]  FAR_BAND_RST     = 8'd36;
   localparam logic [SIM_W-1:0]  MAX_SIMILAR_RST  = 5'd8;
   localparam logic [BRI_W-1:0]  MAX_BRIGHTER_RST = 6'd32;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_MIN_LEVEL    = 3'd2,
      CSR_NEAR_BAND    = 3'd3,
      CSR_FAR_BAND     = 3'd4,
      CSR_MAX_SIMILAR  = 3'd5,
      CSR_MAX_BRIGHTER = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_payload_type;

   typedef struct packed {
      logic              is_target;
      logic [ROW_W-1:0]  out_row;
      logic [OCOL_W-1:0] out_col;
   } rsp_payload_type;

   // Control handed to every window cell.
   typedef struct packed {
      logic shift_en;
      logic cmp_en;
   } cell_ctrl_type;

endpackage

// ----- rtl/stwc_line_store.sv -----
module stwc_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [stwc_pkg::WORD_W-1:0]       wr_data,
   output logic [stwc_pkg::WORD_W-1:0]       rd_data
);

   logic [stwc_pkg::WORD_W-1:0] line_mem [DEPTH];
   logic [stwc_pkg::WORD_W-1:0] rd_data_ff;

   // Write port: one column of four stored lines per beat.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write to the same column in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= line_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stwc_cell.sv -----
module stwc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  stwc_pkg::cell_ctrl_type     ctrl,
   input  logic [stwc_pkg::PIX_W-1:0]  pix_in,
   input  logic [stwc_pkg::PIX_W-1:0]  centre,
   input  logic [stwc_pkg::PIX_W-1:0]  band,
   output logic [stwc_pkg::PIX_W-1:0]  pix_out,
   output logic                        brighter,
   output logic                        similar
);

   localparam int DW = stwc_pkg::PIX_W + 2;

   logic [stwc_pkg::PIX_W-1:0] pix_ff;
   logic                       brighter_ff;
   logic                       brighter_in;
   logic                       similar_ff;
   logic                       similar_in;
   logic signed [DW-1:0]       diff;
   logic signed [DW-1:0]       band_s;

   // Pixel shifts in from the neighbor on the right once per window step.
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else if (ctrl.shift_en) begin
         pix_ff <= pix_in;
      end
   end

   // Compare against the window center: brighter, and strictly inside the band.
   always_comb begin
      diff        = $signed({2'b00, pix_ff}) - $signed({2'b00, centre});
      band_s      = $signed({2'b00, band});
      brighter_in = (diff > $signed(DW'(0)));
      similar_in  = (diff < band_s) && ((-diff) < band_s);
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         brighter_ff <= brighter_in;
         similar_ff  <= similar_in;
      end
   end

   assign pix_out  = pix_ff;
   assign brighter = brighter_ff;
   assign similar  = similar_ff;

endmodule

// ----- rtl/small_target_window_classifier.sv -----
// The result for the pixel two rows and two columns back goes from stage 1 through stages 2 and 3
// into the result register.
// Throughput: one pixel per cycle when nothing stalls, set by the read-modify-write of one
// line-memory column per beat and the one-column shift of the 5x5 cell array.
// Reset (synchronous, active high): counters, pipeline valids and window cells clear, registers
// take their defaults; the line memory is not cleared and holds garbage until written.
module small_target_window_classifier #(
   parameter int MAX_WIDTH = 1024,
   parameter int BORDER    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  stwc_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output stwc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [stwc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stwc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PW  = stwc_pkg::PIX_W;
   localparam int RW  = stwc_pkg::ROW_W;
   localparam int SW  = stwc_pkg::SIZE_W;
   localparam int OCW = stwc_pkg::OCOL_W;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WA  = $clog2(MAX_WIDTH + 1);
   localparam int WW  = (WA > SW) ? WA : SW;
   localparam int N   = stwc_pkg::WIN;
   localparam int C   = stwc_pkg::CENTRE;

   // Configuration registers.
   logic [SW-1:0]                  frame_width_ff;
   logic [SW-1:0]                  frame_height_ff;
   logic [PW-1:0]                  min_level_ff;
   logic [PW-1:0]                  near_band_ff;
   logic [PW-1:0]                  far_band_ff;
   logic [stwc_pkg::SIM_W-1:0]     max_similar_ff;
   logic [stwc_pkg::BRI_W-1:0]     max_brighter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= stwc_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= stwc_pkg::FRAME_HEIGHT_RST;
         min_level_ff    <= stwc_pkg::MIN_LEVEL_RST;
         near_band_ff    <= stwc_pkg::NEAR_BAND_RST;
         far_band_ff     <= stwc_pkg::FAR_BAND_RST;
         max_similar_ff  <= stwc_pkg::MAX_SIMILAR_RST;
         max_brighter_ff <= stwc_pkg::MAX_BRIGHTER_RST;
      end else if (csr_we) begin
         unique case (stwc_pkg::csr_index_type'(csr_index))
            stwc_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            stwc_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            stwc_pkg::CSR_MIN_LEVEL:    min_level_ff    <= csr_wdata[PW-1:0];
            stwc_pkg::CSR_NEAR_BAND:    near_band_ff    <= csr_wdata[PW-1:0];
            stwc_pkg::CSR_FAR_BAND:     far_band_ff     <= csr_wdata[PW-1:0];
            stwc_pkg::CSR_MAX_SIMILAR:  max_similar_ff  <= csr_wdata[stwc_pkg::SIM_W-1:0];
            stwc_pkg::CSR_MAX_BRIGHTER: max_brighter_ff <= csr_wdata[stwc_pkg::BRI_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective row width, limited by the line memory depth.
   logic [WW-1:0] wsat;
   assign wsat = (WW'(frame_width_ff) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width_ff);

   // Pipeline control.
   logic accept;
   logic s1_valid_ff, s1_valid_in, s1_adv;
   logic s2_valid_ff, s2_valid_in, s2_adv, s2_free;
   logic s3_valid_ff, s3_valid_in, s3_adv, s3_free;
   logic rsp_valid_ff, rsp_valid_in, out_free;
   logic s2_emit_ff;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s3_adv    = s3_valid_ff && out_free;
      s3_free   = !s3_valid_ff || out_free;
      s2_adv    = s2_valid_ff && (!s2_emit_ff || s3_free);
      s2_free   = !s2_valid_ff || s2_adv;
      s1_adv    = s1_valid_ff && s2_free;
      req_stall = s1_valid_ff && !s2_free;
      accept    = req_valid && !req_stall;
   end

   // Raster position counters.
   logic [RW-1:0] row_ff, row_in, cur_row;
   logic [CW-1:0] col_ff, col_in, cur_col;
   logic [WW-1:0] col_next;
   logic [RW:0]   row_next;

   always_comb begin
      cur_row  = req_payload.frame_start ? '0 : row_ff;
      cur_col  = req_payload.frame_start ? '0 : col_ff;
      col_next = WW'(cur_col) + WW'(1);
      row_next = (RW+1)'(cur_row) + (RW+1)'(1);
      if (col_next >= wsat) begin
         col_in = '0;
         row_in = (row_next >= (RW+1)'(frame_height_ff)) ? '0 : row_next[RW-1:0];
      end else begin
         col_in = col_next[CW-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Stage 1: beat accepted, line memory column being read.
   logic [PW-1:0] s1_px_ff;
   logic [RW-1:0] s1_row_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_payload.pixel;
         s1_row_ff  <= cur_row;
         s1_col_ff  <= cur_col;
         s1_emit_ff <= (cur_row >= RW'(2)) && (cur_col >= CW'(2));
      end
   end

   // Line memory: one word holds the column of the four stored lines, oldest in the low byte.
   logic [stwc_pkg::WORD_W-1:0] lm_rd_data;
   logic [stwc_pkg::WORD_W-1:0] lm_wr_data;

   assign lm_wr_data = {s1_px_ff, lm_rd_data[stwc_pkg::WORD_W-1:PW]};

   stwc_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (lm_wr_data),
      .rd_data (lm_rd_data)
   );

   // Position of the classified pixel and its border test.
   logic [RW-1:0] s1_rr;
   logic [CW-1:0] s1_cc;
   logic          s1_inside;

   always_comb begin
      s1_rr     = s1_row_ff - RW'(2);
      s1_cc     = s1_col_ff - CW'(2);
      s1_inside = (s1_rr >= RW'(BORDER))
               && (((RW+1)'(s1_rr) + (RW+1)'(BORDER)) < (RW+1)'(frame_height_ff))
               && ((WW+1)'(s1_cc) >= (WW+1)'(BORDER))
               && (((WW+1)'(s1_cc) + (WW+1)'(BORDER)) < (WW+1)'(wsat));
   end

   // Stage 2: window holds the classified pixel's neighborhood.
   logic [RW-1:0] s2_rr_ff;
   logic [CW-1:0] s2_cc_ff;
   logic          s2_inside_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_rr_ff     <= s1_rr;
         s2_cc_ff     <= s1_cc;
         s2_inside_ff <= s1_inside;
         s2_emit_ff   <= s1_emit_ff;
      end
   end

   // The 5x5 cell array: each row shifts left by one column per beat.
   stwc_pkg::cell_ctrl_type cell_ctrl;
   logic [PW-1:0] column [N];
   logic [PW-1:0] win    [N][N];
   logic          bri    [N][N];
   logic          sim    [N][N];

   assign cell_ctrl.shift_en = s1_adv;
   assign cell_ctrl.cmp_en   = s2_adv && s2_emit_ff;

   for (genvar r = 0; r < N; r++) begin : g_col
      if (r < stwc_pkg::LINES) begin : g_mem
         assign column[r] = lm_rd_data[r*PW +: PW];
      end else begin : g_px
         assign column[r] = s1_px_ff;
      end
   end

   for (genvar r = 0; r < N; r++) begin : g_row
      for (genvar k = 0; k < N; k++) begin : g_cell
         localparam bit INNER = (r >= C-1) && (r <= C+1) && (k >= C-1) && (k <= C+1);
         logic [PW-1:0] pix_in;
         logic [PW-1:0] band;

         if (k == N-1) begin : g_edge
            assign pix_in = column[r];
         end else begin : g_link
            assign pix_in = win[r][k+1];
         end
         assign band = INNER ? near_band_ff : far_band_ff;

         stwc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (cell_ctrl),
            .pix_in   (pix_in),
            .centre   (win[C][C]),
            .band     (band),
            .pix_out  (win[r][k]),
            .brighter (bri[r][k]),
            .similar  (sim[r][k])
         );
      end
   end

   // Stage 3: compare flags sit in the cells; tally them here.
   logic [RW-1:0] s3_rr_ff;
   logic [CW-1:0] s3_cc_ff;
   logic          s3_inside_ff;
   logic          s3_level_ok_ff;

   always_ff @(posedge clock) begin
      if (s2_adv && s2_emit_ff) begin
         s3_rr_ff       <= s2_rr_ff;
         s3_cc_ff       <= s2_cc_ff;
         s3_inside_ff   <= s2_inside_ff;
         s3_level_ok_ff <= (win[C][C] >= min_level_ff);
      end
   end

   logic [stwc_pkg::SIM_W-1:0] sim_cnt;
   logic [stwc_pkg::BRI_W-1:0] bri_cnt;
   logic [stwc_pkg::BRI_W-1:0] row_bri [N];
   logic [stwc_pkg::SIM_W-1:0] row_sim [N];

   // Per-row partial counts first, then the five rows; inner brighter pixels count twice.
   always_comb begin
      for (int r = 0; r < N; r++) begin
         row_bri[r] = '0;
         row_sim[r] = '0;
         for (int k = 0; k < N; k++) begin
            if ((r >= C-1) && (r <= C+1) && (k >= C-1) && (k <= C+1)) begin
               row_bri[r] = row_bri[r] + (bri[r][k] ? stwc_pkg::BRI_W'(2) : '0);
            end else begin
               row_bri[r] = row_bri[r] + (bri[r][k] ? stwc_pkg::BRI_W'(1) : '0);
            end
            if (!((r == C) && (k == C))) begin
               row_sim[r] = row_sim[r] + (sim[r][k] ? stwc_pkg::SIM_W'(1) : '0);
            end
         end
      end
      bri_cnt = '0;
      sim_cnt = '0;
      for (int r = 0; r < N; r++) begin
         bri_cnt = bri_cnt + row_bri[r];
         sim_cnt = sim_cnt + row_sim[r];
      end
   end

   // Result register.
   stwc_pkg::rsp_payload_type rsp_payload_ff;
   logic [CW+OCW-1:0]         cc_ext;

   assign cc_ext = {{OCW{1'b0}}, s3_cc_ff};

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         rsp_payload_ff.is_target <= s3_inside_ff && s3_level_ok_ff
                                  && (sim_cnt <= max_similar_ff)
                                  && (bri_cnt <= max_brighter_ff);
         rsp_payload_ff.out_row   <= s3_rr_ff;
         rsp_payload_ff.out_col   <= cc_ext[OCW-1:0];
      end
   end

   // Stage valids.
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      s3_valid_in  = (s2_adv && s2_emit_ff) ? 1'b1 : (s3_adv ? 1'b0 : s3_valid_ff);
      rsp_valid_in = s3_adv ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- dv/target_mark_checker.sv -----
// Watches the pixel, result and register ports of the classifier, rebuilds the
// 5x5 window on its own and compares every result beat with the oldest awaited mark.
module target_mark_checker
   import stwc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int LINE_LENGTH = 1024;
   localparam int BORDER      = 8;
   localparam int PRINT_LIMIT = 40;

   // Shadow copies of the registers.
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   logic [PIX_W-1:0]  min_level_reg;
   logic [PIX_W-1:0]  near_band_reg;
   logic [PIX_W-1:0]  far_band_reg;
   logic [SIM_W-1:0]  max_similar_reg;
   logic [BRI_W-1:0]  max_brighter_reg;

   // Own copy of the stored lines, the window and the raster position.
   logic [PIX_W-1:0] line_mem [LINES][LINE_LENGTH];
   logic [PIX_W-1:0] win [WIN][WIN];
   int row_pos;
   int col_pos;

   rsp_payload_type awaited_marks [$];
   int mismatches;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t: mark mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   // The center passes when it is bright enough, few neighbors look like it and few
   // are brighter. Brighter pixels of the 3x3 count twice, once there and once in the 5x5.
   function automatic logic classify_window();
      int   centre;
      int   a;
      int   near;
      int   far;
      int   similar;
      int   brighter;
      logic inner;
      centre   = win[CENTRE][CENTRE];
      near     = near_band_reg;
      far      = far_band_reg;
      similar  = 0;
      brighter = 0;
      if (centre < min_level_reg) return 1'b0;
      for (int r = 0; r < WIN; r++) begin
         for (int k = 0; k < WIN; k++) begin
            a     = win[r][k];
            inner = r >= 1 && r <= 3 && k >= 1 && k <= 3;
            if (a > centre) brighter += inner ? 2 : 1;
            if (!(r == CENTRE && k == CENTRE)) begin
               if (inner) begin
                  if (a < centre + near && a > centre - near) similar++;
               end else if (a < centre + far && a > centre - far) begin
                  similar++;
               end
            end
         end
      end
      return similar <= max_similar_reg && brighter <= max_brighter_reg;
   endfunction

   // One accepted pixel: rotate the column through the stored lines, shift the window
   // and await a mark for the pixel two rows and two columns back.
   task automatic advance_pixel(input req_payload_type beat);
      logic [PIX_W-1:0] column [WIN];
      rsp_payload_type  mark;
      int               w;
      int               h;
      int               row;
      int               col;
      int               rr;
      int               cc;
      logic             in_frame;
      w = (width_reg > LINE_LENGTH) ? LINE_LENGTH : int'(width_reg);
      h = int'(height_reg);
      if (beat.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      row = row_pos;
      col = col_pos;
      if (col >= LINE_LENGTH) col = 0;

      for (int r = 0; r < LINES; r++) column[r] = line_mem[r][col];
      column[LINES] = beat.pixel;
      for (int r = 0; r < LINES; r++) line_mem[r][col] = column[r + 1];

      for (int r = 0; r < WIN; r++) begin
         for (int k = 0; k < WIN - 1; k++) win[r][k] = win[r][k + 1];
         win[r][WIN - 1] = column[r];
      end

      if (row >= CENTRE && col >= CENTRE) begin
         rr       = row - CENTRE;
         cc       = col - CENTRE;
         in_frame = rr >= BORDER && rr + BORDER < h && cc >= BORDER && cc + BORDER < w;
         mark.is_target = in_frame && classify_window();
         mark.out_row   = ROW_W'(rr);
         mark.out_col   = OCOL_W'(cc);
         awaited_marks.insert(awaited_marks.size(), mark);
      end

      // Column wraps at the line end, row wraps at the frame end.
      if (col + 1 >= w) begin
         col_pos = 0;
         row_pos = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type due;
      if (reset) begin
         width_reg        = FRAME_WIDTH_RST;
         height_reg       = FRAME_HEIGHT_RST;
         min_level_reg    = MIN_LEVEL_RST;
         near_band_reg    = NEAR_BAND_RST;
         far_band_reg     = FAR_BAND_RST;
         max_similar_reg  = MAX_SIMILAR_RST;
         max_brighter_reg = MAX_BRIGHTER_RST;
         foreach (line_mem[r, k]) line_mem[r][k] = '0;
         foreach (win[r, k]) win[r][k] = '0;
         row_pos = 0;
         col_pos = 0;
         awaited_marks.delete();
      end else begin
         // Register writes take effect for the pixels that follow.
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg        = csr_wdata[SIZE_W-1:0];
               CSR_FRAME_HEIGHT: height_reg       = csr_wdata[SIZE_W-1:0];
               CSR_MIN_LEVEL:    min_level_reg    = csr_wdata[PIX_W-1:0];
               CSR_NEAR_BAND:    near_band_reg    = csr_wdata[PIX_W-1:0];
               CSR_FAR_BAND:     far_band_reg     = csr_wdata[PIX_W-1:0];
               CSR_MAX_SIMILAR:  max_similar_reg  = csr_wdata[SIM_W-1:0];
               CSR_MAX_BRIGHTER: max_brighter_reg = csr_wdata[BRI_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) advance_pixel(req_payload);

         // Each result beat must match the oldest awaited mark in every field.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_marks.size() == 0) begin
               report_mismatch($sformatf("result beat row %0d col %0d with no mark awaited",
                                         rsp_payload.out_row, rsp_payload.out_col));
            end else begin
               due = awaited_marks.pop_front();
               if (rsp_payload.is_target !== due.is_target ||
                   rsp_payload.out_row !== due.out_row ||
                   rsp_payload.out_col !== due.out_col) begin
                  report_mismatch($sformatf("got target %b row %0d col %0d, want %b %0d %0d",
                                            rsp_payload.is_target, rsp_payload.out_row,
                                            rsp_payload.out_col, due.is_target,
                                            due.out_row, due.out_col));
               end
            end
         end
      end
      pending_count <= awaited_marks.size();
      fail_count    <= mismatches;
   end

endmodule

// ----- dv/small_target_window_classifier_test.sv -----
module small_target_window_classifier_test;
   import stwc_pkg::*;

   localparam int LINE_LENGTH   = 1024;
   localparam int RANDOM_ITEMS  = 250;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_LIMIT   = 20000;

   typedef enum int {
      SCENE_NOISE,
      SCENE_SPOTS,
      SCENE_FLAT
   } scene_type;

   typedef struct {
      int width;
      int height;
      int min_level;
      int near_band;
      int far_band;
      int max_similar;
      int max_brighter;
   } frame_setting_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   logic tx_idling     = 1'b0;
   logic rx_idling     = 1'b0;
   int   hold_requests = 0;
   int   fail_count;
   int   pending_count;

   // Extreme levels and bit patterns, with a frame start in the middle of a line.
   req_payload_type opening_beats [14] = '{
      {8'd255, 1'b1}, {8'd0, 1'b0},   {8'd255, 1'b0}, {8'd0, 1'b0},
      {8'd128, 1'b0}, {8'd127, 1'b0}, {8'd1, 1'b0},   {8'd254, 1'b0},
      {8'd85, 1'b0},  {8'd170, 1'b0}, {8'd255, 1'b1}, {8'd0, 1'b0},
      {8'd255, 1'b0}, {8'd0, 1'b0}
   };

   small_target_window_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   target_mark_checker marks (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("small_target_window_classifier_test failed");
      $finish;
   end

   // Result side: random stall bursts, free runs, and one long hold-off on request.
   initial begin : receiver
      int holds_done;
      int span;
      holds_done = 0;
      forever begin
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            span = LONG_HOLD;
         end else if (rx_idling && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 15);
         end else begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 15);
         end
         repeat (span) @(posedge clock);
      end
   end

   function automatic logic [PIX_W-1:0] scene_level(input scene_type scene);
      case (scene)
         SCENE_SPOTS: begin
            // Dark background with sparse bright dots that tend to pass.
            if ($urandom_range(0, 15) == 0) return PIX_W'($urandom_range(160, 255));
            return PIX_W'($urandom_range(0, 50));
         end
         SCENE_FLAT: begin
            if ($urandom_range(0, 40) == 0) return PIX_W'(255);
            return PIX_W'($urandom_range(96, 112));
         end
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one pixel beat and returns at the edge that takes it; valid stays high.
   task automatic send_beat(input req_payload_type beat);
      int gap;
      if (tx_idling && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input int value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   // Registers change only once every awaited mark is in and the pipeline has emptied.
   task automatic apply_setting(input frame_setting_type s);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_FRAME_WIDTH, s.width);
      write_csr(CSR_FRAME_HEIGHT, s.height);
      write_csr(CSR_MIN_LEVEL, s.min_level);
      write_csr(CSR_NEAR_BAND, s.near_band);
      write_csr(CSR_FAR_BAND, s.far_band);
      write_csr(CSR_MAX_SIMILAR, s.max_similar);
      write_csr(CSR_MAX_BRIGHTER, s.max_brighter);
      csr_we <= 1'b0;
   endtask

   // A run of pixels, opened by a frame start when fresh; noisy runs also carry
   // stray frame starts that cut a frame short.
   task automatic stream_scene(input int count, input scene_type scene, input bit fresh,
                               input bit noisy);
      req_payload_type beat;
      for (int i = 0; i < count; i++) begin
         beat.pixel       = scene_level(scene);
         beat.frame_start = (i == 0 && fresh) || (noisy && $urandom_range(0, 299) == 0);
         send_beat(beat);
      end
   endtask

   initial begin : stimulus
      frame_setting_type s;
      int                random_items;
      int                count;
      int                phase;
      int                waited;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Tiny frames: every mark lies in the border.
      s = '{3, 5, 0, 0, 255, 0, 0};
      apply_setting(s);
      foreach (opening_beats[i]) send_beat(opening_beats[i]);

      // Zero sizes wrap both counters on every pixel, so nothing is emitted.
      s = '{0, 0, 255, 255, 0, 31, 63};
      apply_setting(s);
      stream_scene(4, SCENE_NOISE, 1'b1, 1'b0);

      // Width above the line length saturates; the first row also writes every column.
      s = '{2047, 2047, 60, 10, 30, 24, 40};
      apply_setting(s);
      stream_scene(LINE_LENGTH + 6, SCENE_SPOTS, 1'b1, 1'b0);

      // Narrow the line in the middle of the frame.
      s.width = 5;
      apply_setting(s);
      stream_scene(30, SCENE_NOISE, 1'b0, 1'b0);

      // Random frames. All columns were written above, so a run may carry on
      // from where the previous one stopped.
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         s.width  = $urandom_range(17, 32);
         s.height = $urandom_range(17, 24);
         case ($urandom_range(0, 4))
            0:       s.min_level = 0;
            1:       s.min_level = 255;
            default: s.min_level = $urandom_range(40, 140);
         endcase
         case ($urandom_range(0, 4))
            0:       s.near_band = 0;
            1:       s.near_band = 255;
            default: s.near_band = $urandom_range(5, 40);
         endcase
         case ($urandom_range(0, 4))
            0:       s.far_band = 0;
            1:       s.far_band = 255;
            default: s.far_band = $urandom_range(10, 70);
         endcase
         case ($urandom_range(0, 5))
            0:       s.max_similar = 0;
            1:       s.max_similar = 24;
            2:       s.max_similar = 31;
            default: s.max_similar = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 5))
            0:       s.max_brighter = 0;
            1:       s.max_brighter = 32;
            2:       s.max_brighter = 63;
            default: s.max_brighter = $urandom_range(4, 40);
         endcase
         count     = $urandom_range(s.width * s.height * 3 / 4, s.width * s.height * 5 / 4);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         tx_idling = (phase != 0) && ($urandom_range(0, 3) != 0);
         rx_idling = $urandom_range(0, 3) != 0;
         apply_setting(s);
         // In the first run the result side holds off while pixels keep coming.
         if (phase == 0) hold_requests++;
         stream_scene(count, scene_type'($urandom_range(0, 2)), $urandom_range(0, 3) != 0,
                      1'b1);
         random_items += count;
         phase++;
      end

      // Closing frame at full rate on both sides: the smallest frame with an inside
      // pixel, run two rows past its end so the row wraps by itself.
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      s = '{17, 17, 72, 18, 36, 8, 32};
      apply_setting(s);
      stream_scene(17 * 17 + 2 * 17, SCENE_SPOTS, 1'b1, 1'b0);
      req_valid <= 1'b0;

      // Let the last marks come out, then let the bench settle.
      waited = 0;
      @(posedge clock);
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("small_target_window_classifier_test passed");
      end else begin
         $display("small_target_window_classifier_test failed");
      end
      $finish;
   end

endmodule

// ----- small_target_window_classifier.f -----
rtl/stwc_pkg.sv
rtl/stwc_line_store.sv
rtl/stwc_cell.sv
rtl/small_target_window_classifier.sv
dv/target_mark_checker.sv
dv/small_target_window_classifier_test.sv
